@@ rtl/least_loaded_bin_assigner_top_assert.svh @@
// ---------------------------------------------------------------------------
// least_loaded_bin_assigner assertion macros
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ---------------------------------------------------------------------------
`ifndef LEAST_LOADED_BIN_ASSIGNER_TOP_ASSERT_SVH
`define LEAST_LOADED_BIN_ASSIGNER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LLBA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define LLBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define LLBA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define LLBA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/llba_pkg.sv @@
// ---------------------------------------------------------------------------
// llba_pkg
// shared widths, constants and sequencer states of the bin assigner
// ---------------------------------------------------------------------------
package llba_pkg;

    localparam int LOAD_W = 32;
    localparam int SIZE_W = 16;
    localparam int BIN_W  = 7;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

@@ rtl/least_loaded_bin_assigner_top.sv @@
// ---------------------------------------------------------------------------
// least_loaded_bin_assigner_top
// greedy list scheduler: each job goes to the bin with the smallest load
// ---------------------------------------------------------------------------
// flow: after the input transfer ST_SCAN compares the bins in use, then ST_DONE posts the result
// with start_new set: a clear sweep of all MAX_BINS bins, then ST_DONE posts the result
// one job at a time: s_tready stays low until the result is posted;
//   the scan makes one load compare per cycle through the single memory read port
// reset: synchronous active low, then a clearing pass over the whole
//   load memory with s_tready low; bin_count resets to 1
// ---------------------------------------------------------------------------
`include "least_loaded_bin_assigner_top_assert.svh"

module least_loaded_bin_assigner_top #(
    parameter int MAX_BINS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,

    // configuration: bin_count
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,   // [6:0] bin_count

    // job input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] job_size
    input  logic        s_tuser,    // [0] start_new

    // result output
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [6:0] bin_chosen, [7] zero
);

    // address width of one bin, counter width that can hold MAX_BINS itself
    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);

    localparam int LW = llba_pkg::LOAD_W;
    localparam int SW = llba_pkg::SIZE_W;
    localparam int BW = llba_pkg::BIN_W;

    // sequencer and datapath registers
    llba_pkg::state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;           // clear sweep / read issue index
    logic [CW-1:0] count_reg, count_next;       // bins in use for this job
    logic          clr_job_reg, clr_job_next;   // clear sweep belongs to a job
    logic          rd_vld_reg, rd_vld_next;     // read data valid next cycle
    logic [AW-1:0] rd_idx_reg, rd_idx_next;     // bin of the data in flight
    logic [AW-1:0] best_reg, best_next;         // running least-loaded bin
    logic [LW-1:0] best_load_reg, best_load_next;
    logic [SW-1:0] size_reg, size_next;
    logic [BW-1:0] bin_count_reg;
    logic          m_valid_reg, m_valid_next;
    logic [BW-1:0] m_data_reg, m_data_next;

    // load memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [LW-1:0] mem_rdata;

    // shared compare unit and the saturating add
    logic          cmp_less;
    logic [LW:0]   load_sum;
    logic [LW-1:0] load_new;
    logic [AW:0]   best_p1;
    logic          out_free;
    logic          in_xfer;

    llba_load_ram #(
        .DEPTH (MAX_BINS),
        .AW    (AW)
    ) u_load_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == llba_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    // result slot can take a new value when empty or being drained
    assign out_free = !m_valid_reg || m_tready;

    // one compare per cycle; the first bin always seeds the minimum
    assign cmp_less = (rd_idx_reg == '0) || (mem_rdata < best_load_reg);

    // load grows by the job size, sticking at the all-ones maximum
    assign load_sum = {1'b0, best_load_reg} + (LW + 1)'(size_reg);
    assign load_new = load_sum[LW] ? llba_pkg::LOAD_MAX : load_sum[LW-1:0];

    // bins are reported counted from 1
    assign best_p1 = {1'b0, best_reg} + (AW + 1)'(1);

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        clr_job_next   = clr_job_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_next      = best_reg;
        best_load_next = best_load_reg;
        size_next      = size_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            llba_pkg::ST_CLEAR: begin
                // zero one bin per cycle over the whole memory
                mem_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(MAX_BINS - 1)) begin
                    idx_next = '0;
                    if (clr_job_reg) begin
                        // all loads are zero, so the first bin wins
                        clr_job_next   = 1'b0;
                        best_next      = '0;
                        best_load_next = '0;
                        state_next     = llba_pkg::ST_DONE;
                    end else begin
                        state_next = llba_pkg::ST_IDLE;
                    end
                end
            end

            llba_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    size_next = s_tdata;
                    idx_next  = '0;
                    // zero bins count as one, too many as MAX_BINS
                    if (bin_count_reg == '0) begin
                        count_next = CW'(1);
                    end else if (32'(bin_count_reg) > MAX_BINS) begin
                        count_next = CW'(MAX_BINS);
                    end else begin
                        count_next = CW'(bin_count_reg);
                    end
                    if (s_tuser) begin
                        clr_job_next = 1'b1;
                        state_next   = llba_pkg::ST_CLEAR;
                    end else begin
                        state_next = llba_pkg::ST_SCAN;
                    end
                end
            end

            llba_pkg::ST_SCAN: begin
                // issue the next read while the previous one is compared
                if (idx_reg < count_reg) begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[AW-1:0];
                    idx_next    = idx_reg + CW'(1);
                end
                if (rd_vld_reg && cmp_less) begin
                    best_next      = rd_idx_reg;
                    best_load_next = mem_rdata;
                end
                if (idx_reg == count_reg && !rd_vld_reg) begin
                    state_next = llba_pkg::ST_DONE;
                end
            end

            llba_pkg::ST_DONE: begin
                // write back the new load and post the result together
                if (out_free) begin
                    mem_we       = 1'b1;
                    mem_waddr    = best_reg;
                    mem_wdata    = load_new;
                    m_valid_next = 1'b1;
                    m_data_next  = BW'(best_p1);
                    state_next   = llba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = llba_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= llba_pkg::ST_CLEAR;
            idx_reg       <= '0;
            clr_job_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            bin_count_reg <= BW'(1);
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            clr_job_reg <= clr_job_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                bin_count_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        best_load_reg <= best_load_next;
        size_reg      <= size_next;
        m_data_reg    <= m_data_next;
    end

    // a result never names bin zero
    `LLBA_ASSERT_IMPL(a_bin_nonzero, aclk, aresetn, m_valid_reg, m_data_reg != '0)

    // one job at a time: no second transfer right after an accepted one
    `LLBA_ASSERT_NEXT(a_one_job, aclk, aresetn, in_xfer, !s_tready)

    // the chosen bin always lies among the bins in use
    `LLBA_ASSERT_IMPL(a_best_in_range, aclk, aresetn,
        state_reg == llba_pkg::ST_DONE, CW'(best_reg) < count_reg)

    // a finished job with a free result slot returns to idle at once
    `LLBA_ASSERT_NEXT(a_done_exit, aclk, aresetn,
        state_reg == llba_pkg::ST_DONE && out_free,
        state_reg == llba_pkg::ST_IDLE && m_valid_reg)

endmodule

@@ rtl/llba_load_ram.sv @@
// ---------------------------------------------------------------------------
// llba_load_ram
// bin load storage, one write port and one registered read port
// ---------------------------------------------------------------------------
module llba_load_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [llba_pkg::LOAD_W-1:0]  wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [llba_pkg::LOAD_W-1:0]  rdata
);

    logic [llba_pkg::LOAD_W-1:0] mem [DEPTH];
    logic [llba_pkg::LOAD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: least_loaded_bin_assigner_top testbench
// sends job sizes over the input stream, mirrors the bin loads and the bin
// count in a local scheduler model, and checks every chosen bin number
// against it; covers count extremes, heavy loads, count changes
// between job sets, backpressure and a long random mix
// ---------------------------------------------------------------------------
module tb_top;

    localparam int MAX_BINS    = 64;
    localparam int IDLE_LIMIT  = 5000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int SHOW_ERRORS = 10;

    // ---------------------------------------------------------------------
    // clock and block ports, every input known from time zero
    // ---------------------------------------------------------------------
    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [llba_pkg::BIN_W-1:0]  cfg_wdata = '0;     // [6:0] bin_count
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [llba_pkg::SIZE_W-1:0] s_tdata   = '0;     // [15:0] job_size
    logic                        s_tuser   = 1'b0;   // [0] start_new
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [7:0]                  m_tdata;            // [6:0] bin_chosen, [7] zero

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    least_loaded_bin_assigner_top #(
        .MAX_BINS (MAX_BINS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ---------------------------------------------------------------------
    // scheduler mirror: bin loads, bin count and the bins still owed
    // ---------------------------------------------------------------------
    logic [llba_pkg::LOAD_W-1:0] load_mirror [MAX_BINS];
    logic [llba_pkg::BIN_W-1:0]  bin_count_mirror = 7'd1;   // reset value
    logic [llba_pkg::BIN_W-1:0]  bins_owed_q [$];

    int  error_count = 0;
    bit  calm = 1'b0;           // suppresses random idling on both sides
    bit  hold_pending = 1'b0;   // asks the receiver for one long hold-off

    initial begin
        foreach (load_mirror[i]) load_mirror[i] = '0;
    end

    // greedy placement: lowest load wins, lowest bin on a tie, load saturates
    function automatic logic [llba_pkg::BIN_W-1:0] place_job(
        logic start, logic [llba_pkg::SIZE_W-1:0] size);
        int span;
        int best;
        span = int'(bin_count_mirror);
        if (span < 1) span = 1;
        if (span > MAX_BINS) span = MAX_BINS;
        if (start) begin
            foreach (load_mirror[i]) load_mirror[i] = '0;
        end
        best = 0;
        for (int i = 1; i < span; i++) begin
            if (load_mirror[i] < load_mirror[best]) best = i;
        end
        if (load_mirror[best] > llba_pkg::LOAD_MAX -
                {{(llba_pkg::LOAD_W-llba_pkg::SIZE_W){1'b0}}, size}) begin
            load_mirror[best] = llba_pkg::LOAD_MAX;
        end else begin
            load_mirror[best] = load_mirror[best] + size;
        end
        return llba_pkg::BIN_W'(best + 1);
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= SHOW_ERRORS) $display("mismatch: %s", msg);
    endtask

    // ---------------------------------------------------------------------
    // input side: one job per call, random gaps unless calm
    // ---------------------------------------------------------------------
    task automatic send_job(logic start, logic [llba_pkg::SIZE_W-1:0] size);
        logic [llba_pkg::BIN_W-1:0] owed_bin;
        while (!calm && $urandom_range(99) < 10) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= size;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        // transfer taken at this edge, predict its bin now
        owed_bin    = place_job(start, size);
        bins_owed_q = {bins_owed_q, owed_bin};
    endtask

    // drop valid and wait until every owed bin number has come back
    task automatic drain_jobs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (bins_owed_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_bin_count(logic [llba_pkg::BIN_W-1:0] value);
        drain_jobs();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        bin_count_mirror = value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [llba_pkg::SIZE_W-1:0] random_job_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return llba_pkg::SIZE_W'($urandom_range(3));     // plenty of ties
        if (pick < 50) return llba_pkg::SIZE_W'($urandom_range(255));
        if (pick < 70) return $urandom_range(1) ? '1 : '0;              // extremes
        return llba_pkg::SIZE_W'($urandom);
    endfunction

    // ---------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request
    // ---------------------------------------------------------------------
    int hold_left = 0;

    always @(negedge aclk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    // compare each result transfer with the oldest owed bin
    always @(posedge aclk) begin
        logic [llba_pkg::BIN_W-1:0] owed;
        if (aresetn && m_tvalid && m_tready) begin
            if (bins_owed_q.size() == 0) begin
                flag_error($sformatf("result bin %0d with no job pending", m_tdata[6:0]));
            end else begin
                owed = bins_owed_q.pop_front();
                if (m_tdata[6:0] !== owed) begin
                    flag_error($sformatf("bin_chosen expected %0d, got %0d",
                                         owed, m_tdata[6:0]));
                end
            end
        end
    end

    // watchdog: cycles in a row without any transfer
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset count, zero and oversized counts, size extremes, start flag
    task automatic test_directed_cases();
        send_job(1'b0, 16'd5);          // reset count of one bin
        send_job(1'b0, 16'd0);
        write_bin_count(7'd4);
        send_job(1'b1, 16'd10);
        send_job(1'b0, 16'd10);
        send_job(1'b0, 16'd0);
        send_job(1'b0, 16'hFFFF);
        send_job(1'b0, 16'd0);          // zero size keeps the tie
        send_job(1'b0, 16'd1);
        send_job(1'b0, 16'd9);
        write_bin_count(7'd0);          // zero count acts as one bin
        send_job(1'b0, 16'd7);
        send_job(1'b1, 16'd3);
        write_bin_count(7'd127);        // oversized count caps at all bins
        send_job(1'b1, 16'd1);
        send_job(1'b0, 16'd2);
        send_job(1'b0, 16'd0);
        write_bin_count(7'd64);
        send_job(1'b1, 16'hFFFF);
        send_job(1'b0, 16'h8000);
        send_job(1'b0, 16'h7FFF);
        send_job(1'b0, 16'h0001);
        drain_jobs();
    endtask

    // one bin loaded with the largest jobs, carries run into the upper load bits
    task automatic test_heavy_loads();
        calm = 1'b1;
        write_bin_count(7'd1);
        send_job(1'b1, 16'hFFFF);
        repeat (30) send_job(1'b0, 16'hFFFF);
        send_job(1'b0, 16'd1);
        send_job(1'b0, 16'd0);
        send_job(1'b0, 16'hFFFF);
        write_bin_count(7'd2);          // loaded bin loses to the empty one
        send_job(1'b0, 16'hFFFF);
        send_job(1'b0, 16'd3);
        calm = 1'b0;
        drain_jobs();
    endtask

    // bins outside a shrunken count keep their load until cleared
    task automatic test_count_change();
        write_bin_count(7'd8);
        send_job(1'b1, 16'd4);
        repeat (12) send_job(1'b0, llba_pkg::SIZE_W'($urandom_range(20)));
        write_bin_count(7'd3);
        repeat (8) send_job(1'b0, llba_pkg::SIZE_W'($urandom_range(20)));
        write_bin_count(7'd8);
        repeat (8) send_job(1'b0, llba_pkg::SIZE_W'($urandom_range(20)));
        drain_jobs();
    endtask

    // receiver holds off while jobs keep coming, input has to stall
    task automatic test_backpressure();
        write_bin_count(7'd16);
        hold_pending = 1'b1;
        repeat (10) send_job($urandom_range(7) == 0, random_job_size());
        drain_jobs();
    endtask

    // random jobs in phases, each phase with its own bin count
    task automatic test_random_mix();
        logic [llba_pkg::BIN_W-1:0] count;
        for (int phase = 0; phase < 11; phase++) begin
            case (phase)
                0:       count = 7'd64;
                1:       count = 7'd1;
                2:       count = 7'd127;
                3:       count = 7'd0;
                4:       count = 7'd65;
                5:       count = 7'd2;
                default: count = llba_pkg::BIN_W'($urandom_range(127));
            endcase
            write_bin_count(count);
            calm = (phase == 6);        // one phase with no idling at all
            repeat (142) send_job($urandom_range(19) == 0, random_job_size());
        end
        calm = 1'b0;
        drain_jobs();
    endtask

    // ---------------------------------------------------------------------
    // sequence: reset once, tests in turn, final verdict
    // ---------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_count_change();
        test_backpressure();
        test_random_mix();
        test_heavy_loads();

        // anything still owed after the tail is a lost result
        drain_jobs();
        repeat (MAX_BINS + 8) @(posedge aclk);
        if (bins_owed_q.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", bins_owed_q.size()));
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
